// File: rtl/box_filter_image_resampler_core_assert.svh
// Assertion macros shared by the checker of the box filter resampler.
// No dependencies; include by bare file name.
`ifndef BOX_FILTER_IMAGE_RESAMPLER_CORE_ASSERT_SVH
`define BOX_FILTER_IMAGE_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define BFIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication under reset.
`define BFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/bfir_pkg.sv
// Types, widths and helpers of the box filter resampler.
// No dependencies.
package bfir_pkg;

	localparam int COORD_W   = 8;
	localparam int SIZE_W    = 9;
	localparam int CHAN_W    = 8;
	localparam int STEP_FRAC = 16;
	localparam int STEP_W    = SIZE_W + STEP_FRAC;
	localparam int SUM_W     = 24;
	localparam int CNT_W     = 17;
	localparam int MUL_W     = COORD_W + STEP_W;
	localparam int REG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_COPY, OP_DIV_GO, OP_DIV_WAIT,
		OP_MUL, OP_BOUND, OP_WALK_INIT, OP_WALK, OP_RESULT
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_STEP_X, SEL_STEP_Y, SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ALPHA
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
		logic     axis_y;
	} dp_cmd_t;

	typedef struct packed {
		logic oor;
		logic copy;
		logic div_done;
		logic walk_last;
		logic out_busy;
	} dp_stat_t;

	// Zero counts as one, anything above the maximum as the maximum.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input int unsigned maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > maxv) begin
			r = SIZE_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: rtl/box_filter_image_resampler_core.sv
// Box filter image resampler, top level.
// Depends on bfir_pkg, bfir_ctrl and bfir_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: command selects a
//   load (write one RGBA source pixel at pos_x/pos_y) or a render (compute
//   destination pixel pos_x/pos_y). Loads outside the source size are dropped
//   and never produce a result. A render produces exactly one result on the
//   output channel (out_valid/out_ready); status high means the position lies
//   outside the target size and all channels read zero.
//   Size registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle; the block itself does not enforce it.
// Sequence: a load is written to the store as it is accepted. A render runs
//   one request at a time: two step divisions (a start step, 25 quotient
//   bits, a done step), multiply and bound steps for x then y, one store read
//   per window pixel plus a drain step, then four channel divisions. Copy mode
//   skips the step divisions and bounds; an out-of-target render goes straight
//   to the result, all on one store read port and one shared serial divider.
// Reset: control state clears, size registers return to 256; the image store
//   keeps its contents and must be loaded before a render reads it.
// Stall: a finished result waits in the output register; new requests are
//   accepted meanwhile, and a second render holds before its result until the
//   output register is taken.
module box_filter_image_resampler_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bfir_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [bfir_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic [bfir_pkg::COORD_W-1:0]     pos_x,
	input  logic [bfir_pkg::COORD_W-1:0]     pos_y,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_red,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_green,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_blue,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_alpha,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bfir_pkg::CHAN_W-1:0]      out_red,
	output logic [bfir_pkg::CHAN_W-1:0]      out_green,
	output logic [bfir_pkg::CHAN_W-1:0]      out_blue,
	output logic [bfir_pkg::CHAN_W-1:0]      out_alpha,
	output logic                             status
);
	import bfir_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each request; the controller sees the handshake, command and datapath status.
	bfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold sizes, store, accumulators, divider and the output register.
	bfir_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.status    (status)
	);
endmodule

// File: rtl/bfir_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bfir_pkg.
module bfir_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bfir_pkg::STEP_W-1:0]   dividend,
	input  logic [bfir_pkg::CNT_W-1:0]    divisor,
	output logic                          done,
	output logic [bfir_pkg::STEP_W-1:0]   quotient
);
	import bfir_pkg::*;

	localparam int CW = $clog2(STEP_W);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [CNT_W-1:0]  rem_q, dvs_q;
	logic [STEP_W-1:0] quo_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[STEP_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
			quo_q <= {quo_q[STEP_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/bfir_dp.sv
// Datapath: size registers, image store, window bounds, accumulators, output register.
// Depends on bfir_pkg and bfir_div.
module bfir_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bfir_pkg::dp_cmd_t                cmd,
	output bfir_pkg::dp_stat_t               stat,
	input  logic                             cfg_write,
	input  logic [bfir_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [bfir_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                             command,
	input  logic [bfir_pkg::COORD_W-1:0]     pos_x,
	input  logic [bfir_pkg::COORD_W-1:0]     pos_y,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_red,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_green,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_blue,
	input  logic [bfir_pkg::CHAN_W-1:0]      in_alpha,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [bfir_pkg::CHAN_W-1:0]      out_red,
	output logic [bfir_pkg::CHAN_W-1:0]      out_green,
	output logic [bfir_pkg::CHAN_W-1:0]      out_blue,
	output logic [bfir_pkg::CHAN_W-1:0]      out_alpha,
	output logic                             status
);
	import bfir_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SIZE_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [SIZE_W-1:0]  sw, sh, tw, th;
	logic [COORD_W-1:0] pos_x_q, pos_y_q;
	logic [STEP_W-1:0]  step_x_q, step_y_q;
	logic [MUL_W-1:0]   mul_s1;
	logic [COORD_W-1:0] x1_q, x2_q, y1_q, y2_q, cx_q, cy_q;
	logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q, sum_a_q;
	logic [CNT_W-1:0]   n_q;
	logic [CHAN_W-1:0]  mean_r_q, mean_g_q, mean_b_q, mean_a_q;
	logic [31:0]        mem [DEPTH];
	logic [31:0]        rd_data_s1;
	logic               rd_vld_s1;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               wr_en;
	logic               out_valid_q, status_q;
	logic [CHAN_W-1:0]  out_r_q, out_g_q, out_b_q, out_a_q;
	logic               div_start, div_done;
	logic [STEP_W-1:0]  div_num, div_quo;
	logic [CNT_W-1:0]   div_den;
	logic [STEP_W-1:0]  step_sel;
	logic [SIZE_W-1:0]  lim;
	logic [MUL_W:0]     b_sum;
	logic [MUL_W-STEP_FRAC:0] b_raw, b_c, a_raw, a_c;

	assign sw = eff_size(src_w_q, MAX_WIDTH);
	assign sh = eff_size(src_h_q, MAX_HEIGHT);
	assign tw = eff_size(dst_w_q, MAX_WIDTH);
	assign th = eff_size(dst_h_q, MAX_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SIZE_RESET;
			src_h_q <= SIZE_RESET;
			dst_w_q <= SIZE_RESET;
			dst_h_q <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH:  dst_w_q <= cfg_data;
				REG_TARGET_HEIGHT: dst_h_q <= cfg_data;
			endcase
		end
	end

	// Image store: one write port, one registered read port.
	assign wr_en = (cmd.op == OP_LATCH) && (command == CMD_LOAD)
		&& ({1'b0, pos_x} < sw) && ({1'b0, pos_y} < sh);
	assign wr_addr = AW'(32'(pos_y) * 32'(MAX_WIDTH) + 32'(pos_x));
	assign rd_addr = AW'(32'(cy_q) * 32'(MAX_WIDTH) + 32'(cx_q));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_alpha, in_blue, in_green, in_red};
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_STEP_X: begin div_num = {sw, STEP_FRAC'(0)}; div_den = CNT_W'(tw); end
			SEL_STEP_Y: begin div_num = {sh, STEP_FRAC'(0)}; div_den = CNT_W'(th); end
			SEL_RED:    begin div_num = STEP_W'(sum_r_q); div_den = n_q; end
			SEL_GREEN:  begin div_num = STEP_W'(sum_g_q); div_den = n_q; end
			SEL_BLUE:   begin div_num = STEP_W'(sum_b_q); div_den = n_q; end
			SEL_ALPHA:  begin div_num = STEP_W'(sum_a_q); div_den = n_q; end
			default:    begin div_num = '0; div_den = CNT_W'(1); end
		endcase
	end

	assign div_start = (cmd.op == OP_DIV_GO);

	bfir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Window bounds: a = floor(i*step), b = floor(i*step + step), clamped.
	assign step_sel = cmd.axis_y ? step_y_q : step_x_q;
	assign lim      = cmd.axis_y ? (sh - SIZE_W'(1)) : (sw - SIZE_W'(1));
	assign b_sum    = {1'b0, mul_s1} + (MUL_W+1)'(step_sel);
	assign b_raw    = b_sum[MUL_W:STEP_FRAC];
	assign a_raw    = {1'b0, mul_s1[MUL_W-1:STEP_FRAC]};
	assign b_c      = (b_raw > ($bits(b_raw))'(lim)) ? ($bits(b_raw))'(lim) : b_raw;
	assign a_c      = (a_raw > b_c) ? b_c : a_raw;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				pos_x_q <= pos_x;
				pos_y_q <= pos_y;
			end
			OP_COPY: begin
				x1_q <= pos_x_q;
				x2_q <= pos_x_q;
				y1_q <= pos_y_q;
				y2_q <= pos_y_q;
			end
			OP_DIV_WAIT: begin
				if (div_done) begin
					unique case (cmd.sel)
						SEL_STEP_X: step_x_q <= div_quo;
						SEL_STEP_Y: step_y_q <= div_quo;
						SEL_RED:    mean_r_q <= CHAN_W'(div_quo);
						SEL_GREEN:  mean_g_q <= CHAN_W'(div_quo);
						SEL_BLUE:   mean_b_q <= CHAN_W'(div_quo);
						SEL_ALPHA:  mean_a_q <= CHAN_W'(div_quo);
						default:    ;
					endcase
				end
			end
			OP_MUL: begin
				mul_s1 <= (cmd.axis_y ? pos_y_q : pos_x_q) * step_sel;
			end
			OP_BOUND: begin
				if (cmd.axis_y) begin
					y1_q <= COORD_W'(a_c);
					y2_q <= COORD_W'(b_c);
				end else begin
					x1_q <= COORD_W'(a_c);
					x2_q <= COORD_W'(b_c);
				end
			end
			OP_WALK_INIT: begin
				cx_q <= x1_q;
				cy_q <= y1_q;
			end
			OP_WALK: begin
				if (cx_q == x2_q) begin
					cx_q <= x1_q;
					cy_q <= cy_q + COORD_W'(1);
				end else begin
					cx_q <= cx_q + COORD_W'(1);
				end
			end
			default: ;
		endcase

		if (cmd.op == OP_WALK_INIT) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			sum_a_q <= '0;
			n_q     <= '0;
		end else if (rd_vld_s1) begin
			sum_r_q <= sum_r_q + SUM_W'(rd_data_s1[7:0]);
			sum_g_q <= sum_g_q + SUM_W'(rd_data_s1[15:8]);
			sum_b_q <= sum_b_q + SUM_W'(rd_data_s1[23:16]);
			sum_a_q <= sum_a_q + SUM_W'(rd_data_s1[31:24]);
			n_q     <= n_q + CNT_W'(1);
		end

		if (cmd.op == OP_RESULT) begin
			status_q <= stat.oor;
			out_r_q  <= stat.oor ? '0 : mean_r_q;
			out_g_q  <= stat.oor ? '0 : mean_g_q;
			out_b_q  <= stat.oor ? '0 : mean_b_q;
			out_a_q  <= stat.oor ? '0 : mean_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (cmd.op == OP_WALK);
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.oor       = ({1'b0, pos_x_q} >= tw) || ({1'b0, pos_y_q} >= th);
	assign stat.copy      = (tw == sw) && (th == sh);
	assign stat.div_done  = div_done;
	assign stat.walk_last = (cx_q == x2_q) && (cy_q == y2_q);
	assign stat.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_red   = out_r_q;
	assign out_green = out_g_q;
	assign out_blue  = out_b_q;
	assign out_alpha = out_a_q;
	assign status    = status_q;
endmodule

// File: rtl/bfir_ctrl.sv
// Controller state machine sequencing loads and renders over the datapath.
// Depends on bfir_pkg.
module bfir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  bfir_pkg::dp_stat_t  stat,
	output bfir_pkg::dp_cmd_t   cmd
);
	import bfir_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_MUL_X, S_BND_X, S_MUL_Y,
		S_BND_Y, S_WINIT, S_WALK, S_DRAIN, S_RESULT
	} state_t;

	state_t   state_q;
	div_sel_t sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_STEP_X;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && command == CMD_RENDER) state_q <= S_CHECK;
				end
				S_CHECK: begin
					priority if (stat.oor) begin
						state_q <= S_RESULT;
					end else if (stat.copy) begin
						state_q <= S_WINIT;
					end else begin
						sel_q   <= SEL_STEP_X;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						unique case (sel_q)
							SEL_STEP_X: begin sel_q <= SEL_STEP_Y; state_q <= S_DIV_GO; end
							SEL_STEP_Y: state_q <= S_MUL_X;
							SEL_RED:    begin sel_q <= SEL_GREEN; state_q <= S_DIV_GO; end
							SEL_GREEN:  begin sel_q <= SEL_BLUE; state_q <= S_DIV_GO; end
							SEL_BLUE:   begin sel_q <= SEL_ALPHA; state_q <= S_DIV_GO; end
							default:    state_q <= S_RESULT;
						endcase
					end
				end
				S_MUL_X: state_q <= S_BND_X;
				S_BND_X: state_q <= S_MUL_Y;
				S_MUL_Y: state_q <= S_BND_Y;
				S_BND_Y: state_q <= S_WINIT;
				S_WINIT: state_q <= S_WALK;
				S_WALK: begin
					if (stat.walk_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					sel_q   <= SEL_RED;
					state_q <= S_DIV_GO;
				end
				S_RESULT: begin
					if (!stat.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.sel    = sel_q;
		cmd.axis_y = 1'b0;
		unique case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_LATCH : OP_NONE;
			S_CHECK:    cmd.op = (!stat.oor && stat.copy) ? OP_COPY : OP_NONE;
			S_DIV_GO:   cmd.op = OP_DIV_GO;
			S_DIV_WAIT: cmd.op = OP_DIV_WAIT;
			S_MUL_X:    cmd.op = OP_MUL;
			S_BND_X:    cmd.op = OP_BOUND;
			S_MUL_Y:    begin cmd.op = OP_MUL; cmd.axis_y = 1'b1; end
			S_BND_Y:    begin cmd.op = OP_BOUND; cmd.axis_y = 1'b1; end
			S_WINIT:    cmd.op = OP_WALK_INIT;
			S_WALK:     cmd.op = OP_WALK;
			S_RESULT:   cmd.op = stat.out_busy ? OP_NONE : OP_RESULT;
			default:    cmd.op = OP_NONE;
		endcase
	end
endmodule

// File: rtl/bfir_checker.sv
// Port-level checker for the box filter resampler, bound to the top level.
// Depends on bfir_pkg and the assertion macro header.
`include "box_filter_image_resampler_core_assert.svh"

module bfir_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         command,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bfir_pkg::CHAN_W-1:0]  out_red,
	input logic [bfir_pkg::CHAN_W-1:0]  out_green,
	input logic [bfir_pkg::CHAN_W-1:0]  out_blue,
	input logic [bfir_pkg::CHAN_W-1:0]  out_alpha,
	input logic                         status
);
	import bfir_pkg::*;

	`BFIR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`BFIR_ASSERT_IMPL(a_oor_zero, clk, arst_n, out_valid && status, (out_red == '0) && (out_green == '0) && (out_blue == '0) && (out_alpha == '0))
	`BFIR_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && in_ready && command == CMD_LOAD && !out_valid, !out_valid)
	`BFIR_ASSERT_NEXT(a_render_busy, clk, arst_n, in_valid && in_ready && command == CMD_RENDER, !in_ready)
endmodule

bind box_filter_image_resampler_core bfir_checker u_bfir_checker (.*);

// File: verif/tb_box_filter_image_resampler_core.sv
// Self-checking testbench of box_filter_image_resampler_core: random loads and renders
// under several size settings, checked against an in-bench area-average predictor.
// Depends on bfir_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_box_filter_image_resampler_core;
	import bfir_pkg::*;

	typedef struct packed {
		logic              cmd;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] a;
	} pixel_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] a;
		logic              oor;
	} pixel_res_t;

	localparam int MAX_DIM     = 256;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CMD_LOAD;
	logic [COORD_W-1:0] pos_x = '0, pos_y = '0;
	logic [CHAN_W-1:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAN_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic status;

	box_filter_image_resampler_core uut (.*);

	// Shadow of the block's registers and image store.
	logic [SIZE_W-1:0] size_reg [4];
	logic [31:0] pixel_mem [MAX_DIM*MAX_DIM];

	pixel_req_t pending_reqs [$];
	pixel_res_t expected_pixels [$];
	int error_count = 0;
	int cycle_count = 0;
	bit steady_flow = 0;   // set to suppress idling on both sides

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned eff_dim(logic [SIZE_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	// Inclusive source span covered by destination index i.
	function automatic void span(int unsigned i, int unsigned src, int unsigned dst,
			output int unsigned lo, output int unsigned hi);
		longint unsigned step, a, b;
		step = (longint'(src) << STEP_FRAC) / dst;
		a = (i * step) >> STEP_FRAC;
		b = ((i + 1) * step) >> STEP_FRAC;
		if (b > src - 1) b = src - 1;
		if (a > b) a = b;
		lo = 32'(a);
		hi = 32'(b);
	endfunction

	// Apply one accepted request to the shadow state; return 1 with the
	// expected pixel when a render.
	function automatic bit resample_pixel(pixel_req_t q, output pixel_res_t res);
		int unsigned sw, sh, tw, th, x1, x2, y1, y2, n;
		longint unsigned sr, sg, sb, sa;
		logic [31:0] p;
		sw = eff_dim(size_reg[REG_SOURCE_WIDTH]);
		sh = eff_dim(size_reg[REG_SOURCE_HEIGHT]);
		tw = eff_dim(size_reg[REG_TARGET_WIDTH]);
		th = eff_dim(size_reg[REG_TARGET_HEIGHT]);
		res = '0;
		if (q.cmd == CMD_LOAD) begin
			if (q.x < sw && q.y < sh)
				pixel_mem[q.y*MAX_DIM + q.x] = {q.a, q.b, q.g, q.r};
			return 0;
		end
		if (q.x >= tw || q.y >= th) begin
			res.oor = 1'b1;
			return 1;
		end
		if (tw == sw && th == sh) begin
			p = pixel_mem[q.y*MAX_DIM + q.x];
			res.r = p[7:0]; res.g = p[15:8]; res.b = p[23:16]; res.a = p[31:24];
			return 1;
		end
		span(q.x, sw, tw, x1, x2);
		span(q.y, sh, th, y1, y2);
		sr = 0; sg = 0; sb = 0; sa = 0; n = 0;
		for (int unsigned yy = y1; yy <= y2; yy++) begin
			for (int unsigned xx = x1; xx <= x2; xx++) begin
				p = pixel_mem[yy*MAX_DIM + xx];
				sr += p[7:0]; sg += p[15:8]; sb += p[23:16]; sa += p[31:24];
				n++;
			end
		end
		res.r = CHAN_W'(sr / n);
		res.g = CHAN_W'(sg / n);
		res.b = CHAN_W'(sb / n);
		res.a = CHAN_W'(sa / n);
		return 1;
	endfunction

	// Driver: present the next pending request, hold it until accepted.
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t nxt;
		pixel_res_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (resample_pixel({command, pos_x, pos_y, in_red, in_green, in_blue,
						in_alpha}, res))
					expected_pixels.push_back(res);
			end
			if (!in_valid || in_ready) begin
				// Idle now and then, unless a steady stretch is running.
				if (pending_reqs.size() > 0 &&
						(steady_flow || $urandom_range(99) >= 18)) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					command <= nxt.cmd;
					pos_x <= nxt.x;
					pos_y <= nxt.y;
					in_red <= nxt.r;
					in_green <= nxt.g;
					in_blue <= nxt.b;
					in_alpha <= nxt.a;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall the output at random and check each result in order.
	always @(posedge clk or negedge arst_n) begin
		pixel_res_t exp_px;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result: red %0d green %0d blue %0d alpha %0d status %0d",
						out_red, out_green, out_blue, out_alpha, status);
					error_count++;
				end else begin
					exp_px = expected_pixels.pop_front();
					if (out_red !== exp_px.r) begin
						$error("out_red expected %0d actual %0d", exp_px.r, out_red);
						error_count++;
					end
					if (out_green !== exp_px.g) begin
						$error("out_green expected %0d actual %0d", exp_px.g, out_green);
						error_count++;
					end
					if (out_blue !== exp_px.b) begin
						$error("out_blue expected %0d actual %0d", exp_px.b, out_blue);
						error_count++;
					end
					if (out_alpha !== exp_px.a) begin
						$error("out_alpha expected %0d actual %0d", exp_px.a, out_alpha);
						error_count++;
					end
					if (status !== exp_px.oor) begin
						$error("status expected %0d actual %0d", exp_px.oor, status);
						error_count++;
					end
				end
			end
			out_ready <= steady_flow || $urandom_range(99) >= 18;
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_size(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		size_reg[idx] = v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Hold until every request is taken and every result checked.
	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic pixel_req_t make_req(logic cmd, int unsigned x, int unsigned y);
		pixel_req_t q;
		q.cmd = cmd;
		q.x = COORD_W'(x);
		q.y = COORD_W'(y);
		q.r = CHAN_W'($urandom_range(255));
		q.g = CHAN_W'($urandom_range(255));
		q.b = CHAN_W'($urandom_range(255));
		q.a = CHAN_W'($urandom_range(255));
		return q;
	endfunction

	// Set the sizes, then write every source pixel so that no render touches an unwritten entry.
	task automatic set_sizes_and_fill(logic [SIZE_W-1:0] sw, logic [SIZE_W-1:0] sh,
			logic [SIZE_W-1:0] tw, logic [SIZE_W-1:0] th);
		write_size(REG_SOURCE_WIDTH, sw);
		write_size(REG_SOURCE_HEIGHT, sh);
		write_size(REG_TARGET_WIDTH, tw);
		write_size(REG_TARGET_HEIGHT, th);
		for (int unsigned y = 0; y < eff_dim(sh); y++)
			for (int unsigned x = 0; x < eff_dim(sw); x++)
				pending_reqs.push_back(make_req(CMD_LOAD, x, y));
	endtask

	// Mixed random traffic: mostly in-target renders, some loads and strays.
	task automatic random_mix(int count, bit hold_mid);
		int unsigned sw, sh, tw, th, pick;
		sw = eff_dim(size_reg[REG_SOURCE_WIDTH]);
		sh = eff_dim(size_reg[REG_SOURCE_HEIGHT]);
		tw = eff_dim(size_reg[REG_TARGET_WIDTH]);
		th = eff_dim(size_reg[REG_TARGET_HEIGHT]);
		for (int i = 0; i < count; i++) begin
			if (hold_mid && i == count / 2) begin
				// Let the block empty out before sending more.
				while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 55)
				pending_reqs.push_back(make_req(CMD_RENDER, $urandom_range(tw - 1),
					$urandom_range(th - 1)));
			else if (pick < 68)
				pending_reqs.push_back(make_req(CMD_RENDER, $urandom_range(255),
					$urandom_range(255)));
			else if (pick < 88)
				pending_reqs.push_back(make_req(CMD_LOAD, $urandom_range(sw - 1),
					$urandom_range(sh - 1)));
			else
				pending_reqs.push_back(make_req(CMD_LOAD, $urandom_range(255),
					$urandom_range(255)));
		end
	endtask

	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned pick;
		pick = $urandom_range(19);
		if (pick == 0) return '0;
		if (pick == 1) return 9'd511;
		if (pick == 2) return 9'd256;
		return SIZE_W'($urandom_range(1, 12));
	endfunction

	initial begin
		pixel_req_t q;
		int phase;
		logic [SIZE_W-1:0] tw, th;
		foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Copy mode on a 2x2 source with extreme channel values.
		write_size(REG_SOURCE_WIDTH, 9'd2);
		write_size(REG_SOURCE_HEIGHT, 9'd2);
		write_size(REG_TARGET_WIDTH, 9'd2);
		write_size(REG_TARGET_HEIGHT, 9'd2);
		q = '{CMD_LOAD, 8'd0, 8'd0, 8'h00, 8'hff, 8'h00, 8'hff};
		pending_reqs.push_back(q);
		q = '{CMD_LOAD, 8'd1, 8'd0, 8'hff, 8'h00, 8'hff, 8'h00};
		pending_reqs.push_back(q);
		q = '{CMD_LOAD, 8'd0, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff};
		pending_reqs.push_back(q);
		q = '{CMD_LOAD, 8'd1, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00};
		pending_reqs.push_back(q);
		// Drop a load outside the source.
		q = '{CMD_LOAD, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 8'hff};
		pending_reqs.push_back(q);
		q = '{CMD_LOAD, 8'd2, 8'd0, 8'h55, 8'haa, 8'h55, 8'haa};
		pending_reqs.push_back(q);
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < 2; x++)
				pending_reqs.push_back(make_req(CMD_RENDER, x, y));
		// Renders outside the target.
		pending_reqs.push_back(make_req(CMD_RENDER, 255, 0));
		pending_reqs.push_back(make_req(CMD_RENDER, 0, 255));
		pending_reqs.push_back(make_req(CMD_RENDER, 255, 255));
		drain();

		// Downscale 2x2 to 1x1 via zero-sized target registers.
		write_size(REG_TARGET_WIDTH, 9'd0);
		write_size(REG_TARGET_HEIGHT, 9'd0);
		pending_reqs.push_back(make_req(CMD_RENDER, 0, 0));
		pending_reqs.push_back(make_req(CMD_RENDER, 1, 0));
		// Upscale, window clamped at the source edge.
		drain();
		write_size(REG_TARGET_WIDTH, 9'd3);
		write_size(REG_TARGET_HEIGHT, 9'd5);
		pending_reqs.push_back(make_req(CMD_RENDER, 2, 4));
		pending_reqs.push_back(make_req(CMD_RENDER, 1, 2));
		drain();

		// Full-width row averaged to one pixel: oversize register clamps to 256.
		set_sizes_and_fill(9'd511, 9'd1, 9'd1, 9'd1);
		pending_reqs.push_back(make_req(CMD_RENDER, 0, 0));
		pending_reqs.push_back(make_req(CMD_LOAD, 255, 0));
		pending_reqs.push_back(make_req(CMD_RENDER, 0, 0));
		drain();

		// Tall column, zero source width, scaled to 3 rows.
		set_sizes_and_fill(9'd0, 9'd64, 9'd1, 9'd3);
		random_mix(12, 0);
		drain();

		// Random phases with small images.
		for (phase = 0; phase < 6; phase++) begin
			tw = rand_size();
			th = rand_size();
			set_sizes_and_fill(SIZE_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(1, 8)),
				tw, th);
			steady_flow = (phase == 3);
			random_mix(14, phase == 5);
			drain();
			steady_flow = 0;
		end

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
